// File: hdl/sqltl_pkg.sv
package sqltl_pkg;

    localparam int KEYWORD_MAX_LEN = 10;
    localparam int POSITION_BITS   = 16;

    localparam int KW_COUNT   = 69;
    localparam int KW_ROW_LEN = 10;

    // record kinds
    localparam logic [1:0] REC_VALUE = 2'd0;
    localparam logic [1:0] REC_TOKEN = 2'd1;
    localparam logic [1:0] REC_ERROR = 2'd2;

    // token types
    localparam logic [6:0] TOK_IDENT  = 7'd0;
    localparam logic [6:0] TOK_STRING = 7'd1;
    localparam logic [6:0] TOK_NUMBER = 7'd2;
    localparam logic [6:0] TOK_KW0    = 7'd3;
    localparam logic [6:0] TOK_EQ     = 7'd72;
    localparam logic [6:0] TOK_NE     = 7'd73;
    localparam logic [6:0] TOK_LT     = 7'd74;
    localparam logic [6:0] TOK_LE     = 7'd75;
    localparam logic [6:0] TOK_GT     = 7'd76;
    localparam logic [6:0] TOK_GE     = 7'd77;
    localparam logic [6:0] TOK_PLUS   = 7'd78;
    localparam logic [6:0] TOK_MINUS  = 7'd79;
    localparam logic [6:0] TOK_STAR   = 7'd80;
    localparam logic [6:0] TOK_SLASH  = 7'd81;
    localparam logic [6:0] TOK_MOD    = 7'd82;
    localparam logic [6:0] TOK_CONCAT = 7'd83;
    localparam logic [6:0] TOK_LPAREN = 7'd84;
    localparam logic [6:0] TOK_RPAREN = 7'd85;
    localparam logic [6:0] TOK_COMMA  = 7'd86;
    localparam logic [6:0] TOK_DOT    = 7'd87;
    localparam logic [6:0] TOK_SEMI   = 7'd88;
    localparam logic [6:0] TOK_EOF    = 7'd89;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BLOCK_CMT = 3'd1;
    localparam logic [2:0] ERR_STRING    = 3'd2;
    localparam logic [2:0] ERR_QIDENT    = 3'd3;
    localparam logic [2:0] ERR_LEAD_ZERO = 3'd4;
    localparam logic [2:0] ERR_BAD_CHAR  = 3'd5;

    localparam logic [79:0] KW_TEXT [KW_COUNT] = '{
        "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
        "DELETE", "CREATE", "TABLE", "DROP", "ALTER", "ADD", "MODIFY", "PRIMARY",
        "KEY", "NOT", "NULL", "UNIQUE", "FOREIGN", "REFERENCES", "DEFAULT",
        "CHECK", "CONSTRAINT", "AND", "OR", "IN", "BETWEEN", "LIKE", "IS",
        "ORDER", "BY", "GROUP", "HAVING", "LIMIT", "OFFSET", "DISTINCT", "INNER",
        "LEFT", "RIGHT", "FULL", "OUTER", "JOIN", "ON", "USING", "UNION",
        "INTERSECT", "EXCEPT", "CASE", "WHEN", "THEN", "ELSE", "END", "AS", "ASC",
        "DESC", "INT", "BIGINT", "FLOAT", "DOUBLE", "DECIMAL", "VARCHAR", "CHAR",
        "BOOLEAN", "DATE", "TIMESTAMP", "TEXT", "BLOB"
    };

    localparam int KW_LEN [KW_COUNT] = '{
        6, 4, 5, 6, 4, 6, 6, 3, 6, 6, 5, 4, 5, 3, 6, 7, 3, 3, 4, 6, 7, 10, 7,
        5, 10, 3, 2, 2, 7, 4, 2, 5, 2, 5, 6, 5, 6, 8, 5, 4, 5, 4, 5, 4, 2, 5, 5,
        9, 6, 4, 4, 4, 4, 3, 2, 3, 4, 3, 6, 5, 6, 7, 7, 4, 7, 4, 9, 4, 4
    };

    // literals are right-justified: first character is the highest used byte
    function automatic logic [7:0] kw_char(int k, int i);
        return KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8];
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

endpackage

// File: hdl/sqltl_kw_match.sv
module sqltl_kw_match #(
    parameter int KEYWORD_MAX_LEN = sqltl_pkg::KEYWORD_MAX_LEN
) (
    input  logic [7:0]                           i_buf [KEYWORD_MAX_LEN],
    input  logic [$clog2(KEYWORD_MAX_LEN+1)-1:0] i_len,
    input  logic                                 i_long,
    output logic [6:0]                           o_type
);
    localparam int LW = $clog2(KEYWORD_MAX_LEN + 1);

    // all rows compared in parallel; keywords are unique so at most one hits
    always_comb begin
        logic hit;
        o_type = sqltl_pkg::TOK_IDENT;
        for (int k = 0; k < sqltl_pkg::KW_COUNT; k++) begin
            hit = (i_len == LW'(sqltl_pkg::KW_LEN[k]));
            for (int i = 0; i < sqltl_pkg::KW_ROW_LEN; i++) begin
                if (i < sqltl_pkg::KW_LEN[k] && i_buf[i] != sqltl_pkg::kw_char(k, i))
                    hit = 1'b0;
            end
            if (hit && !i_long)
                o_type = 7'(sqltl_pkg::TOK_KW0 + 7'(k));
        end
    end
endmodule

// File: hdl/sql_token_lexer_top.sv
// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_char_in, i_end_of_text
// output  | o_valid | i_stall | o_record_kind, o_token_type, o_value_char, o_token_line,
//         |         |         | o_token_column, o_error_code, o_last
// Each byte is lexed combinationally; its records (at most two) land in a two-entry
// output buffer. A byte is taken each cycle while it yields at most one record and
// i_stall is low; a byte yielding two records holds the input while the buffer drains.
// i_rst_n is synchronous, active low; an end-of-text beat also returns the lexer to reset.
// o_stall rises only while the buffer holds records that will not all leave this cycle.
module sql_token_lexer_top #(
    parameter int KEYWORD_MAX_LEN = sqltl_pkg::KEYWORD_MAX_LEN,
    parameter int POSITION_BITS   = sqltl_pkg::POSITION_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [7:0]               i_char_in,
    input  logic                     i_end_of_text,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [1:0]               o_record_kind,
    output logic [6:0]               o_token_type,
    output logic [7:0]               o_value_char,
    output logic [POSITION_BITS-1:0] o_token_line,
    output logic [POSITION_BITS-1:0] o_token_column,
    output logic [2:0]               o_error_code,
    output logic                     o_last
);
    localparam int PB = POSITION_BITS;
    localparam int K  = KEYWORD_MAX_LEN;
    localparam int LW = $clog2(K + 1);
    localparam int KI = $clog2(K);

    localparam logic [3:0] M_IDLE       = 4'd0;
    localparam logic [3:0] M_IDENT      = 4'd1;
    localparam logic [3:0] M_NUMBER     = 4'd2;
    localparam logic [3:0] M_STRING     = 4'd3;
    localparam logic [3:0] M_STRING_ESC = 4'd4;
    localparam logic [3:0] M_QIDENT     = 4'd5;
    localparam logic [3:0] M_QIDENT_ESC = 4'd6;
    localparam logic [3:0] M_LINE_CMT   = 4'd7;
    localparam logic [3:0] M_BLOCK_CMT  = 4'd8;
    localparam logic [3:0] M_BLOCK_STAR = 4'd9;
    localparam logic [3:0] M_PEND       = 4'd10;

    typedef struct packed {
        logic [1:0]    kind;
        logic [6:0]    ttype;
        logic [7:0]    val;
        logic [PB-1:0] ln;
        logic [PB-1:0] col;
        logic [2:0]    err;
    } t_rec;

    function automatic t_rec mk(logic [1:0] kind, logic [6:0] ttype, logic [7:0] val,
                                logic [PB-1:0] ln, logic [PB-1:0] col, logic [2:0] err);
        t_rec r;
        r.kind = kind; r.ttype = ttype; r.val = val;
        r.ln = ln; r.col = col; r.err = err;
        return r;
    endfunction

    logic [3:0]    r_mode, n_mode;
    logic [7:0]    r_kbuf [K];
    logic [7:0]    n_kbuf [K];
    logic [LW-1:0] r_len, n_len;
    logic          r_long, n_long;
    logic [7:0]    r_pend, n_pend;
    logic          r_dot, n_dot;
    logic          r_lz, n_lz;
    logic          r_nmulti, n_nmulti;
    logic [PB-1:0] r_cur_ln, n_cur_ln, r_cur_col, n_cur_col;
    logic [PB-1:0] r_st_ln, n_st_ln, r_st_col, n_st_col;
    logic          r_halt, n_halt;

    t_rec          r_q0, r_q1;
    logic [1:0]    r_qn;

    t_rec          w_rec [2];
    logic [1:0]    w_cnt;
    logic [6:0]    w_kw;
    logic          w_in_acc, w_out_acc;

    sqltl_kw_match #(.KEYWORD_MAX_LEN(K)) u_kw (
        .i_buf  (r_kbuf),
        .i_len  (r_len),
        .i_long (r_long),
        .o_type (w_kw)
    );

    assign o_valid   = (r_qn != 2'd0);
    assign w_out_acc = o_valid && !i_stall;
    assign o_stall   = (r_qn > 2'd1) || ((r_qn == 2'd1) && i_stall);
    assign w_in_acc  = i_valid && !o_stall;

    assign o_record_kind  = r_q0.kind;
    assign o_token_type   = r_q0.ttype;
    assign o_value_char   = r_q0.val;
    assign o_token_line   = r_q0.ln;
    assign o_token_column = r_q0.col;
    assign o_error_code   = r_q0.err;
    assign o_last         = (r_qn == 2'd1);

    always_comb begin
        logic [7:0] c;
        logic       fin;
        logic       do_begin;
        logic [6:0] t;
        c        = i_char_in;
        fin      = !r_halt && (i_end_of_text || c == 8'd0);
        do_begin = 1'b0;
        t        = sqltl_pkg::TOK_IDENT;
        w_cnt    = 2'd0;
        w_rec[0] = '0;
        w_rec[1] = '0;
        n_mode   = r_mode;
        n_kbuf   = r_kbuf;
        n_len    = r_len;
        n_long   = r_long;
        n_pend   = r_pend;
        n_dot    = r_dot;
        n_lz     = r_lz;
        n_nmulti = r_nmulti;
        n_cur_ln = r_cur_ln;
        n_cur_col = r_cur_col;
        n_st_ln  = r_st_ln;
        n_st_col = r_st_col;
        n_halt   = r_halt;

        if (fin) begin
            case (r_mode)
                M_IDENT: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, w_kw, 8'd0, r_st_ln, r_st_col,
                                         sqltl_pkg::ERR_NONE);
                    w_cnt = w_cnt + 2'd1;
                end
                M_NUMBER: begin
                    if (!r_dot && r_lz && r_nmulti) begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln,
                                             r_st_col, sqltl_pkg::ERR_LEAD_ZERO);
                        n_halt = 1'b1;
                    end else begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_NUMBER, 8'd0,
                                             r_st_ln, r_st_col, sqltl_pkg::ERR_NONE);
                    end
                    w_cnt = w_cnt + 2'd1;
                end
                M_STRING, M_STRING_ESC: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln, r_st_col,
                                         sqltl_pkg::ERR_STRING);
                    w_cnt = w_cnt + 2'd1;
                    n_halt = 1'b1;
                end
                M_QIDENT, M_QIDENT_ESC: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln, r_st_col,
                                         sqltl_pkg::ERR_QIDENT);
                    w_cnt = w_cnt + 2'd1;
                    n_halt = 1'b1;
                end
                M_BLOCK_CMT, M_BLOCK_STAR: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln, r_st_col,
                                         sqltl_pkg::ERR_BLOCK_CMT);
                    w_cnt = w_cnt + 2'd1;
                    n_halt = 1'b1;
                end
                M_PEND: begin
                    if (r_pend == "-" || r_pend == "/" || r_pend == "<" || r_pend == ">") begin
                        t = (r_pend == "-") ? sqltl_pkg::TOK_MINUS :
                            (r_pend == "/") ? sqltl_pkg::TOK_SLASH :
                            (r_pend == "<") ? sqltl_pkg::TOK_LT : sqltl_pkg::TOK_GT;
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, t, 8'd0, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                    end else begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln,
                                             r_st_col, sqltl_pkg::ERR_BAD_CHAR);
                        n_halt = 1'b1;
                    end
                    w_cnt = w_cnt + 2'd1;
                end
                default: ;
            endcase
            if (!n_halt) begin
                w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_EOF, 8'd0, r_cur_ln,
                                     r_cur_col, sqltl_pkg::ERR_NONE);
                w_cnt = w_cnt + 2'd1;
            end
            n_mode = M_IDLE;
            n_halt = 1'b1;
        end else if (!r_halt && !i_end_of_text) begin
            case (r_mode)
                M_IDENT: begin
                    if (sqltl_pkg::is_word(c)) begin
                        if (r_len >= LW'(K)) begin
                            n_long = 1'b1;
                        end else begin
                            n_kbuf[r_len[KI-1:0]] = sqltl_pkg::to_upper(c);
                            n_len = r_len + 1'b1;
                        end
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                    end else begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, w_kw, 8'd0, r_st_ln,
                                             r_st_col, sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                        n_mode = M_IDLE;
                        do_begin = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (sqltl_pkg::is_digit(c) || (c == "." && !r_dot)) begin
                        if (c == ".") n_dot = 1'b1;
                        n_nmulti = 1'b1;
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                    end else begin
                        if (!r_dot && r_lz && r_nmulti) begin
                            w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln,
                                                 r_st_col, sqltl_pkg::ERR_LEAD_ZERO);
                            n_halt = 1'b1;
                        end else begin
                            w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_NUMBER,
                                                 8'd0, r_st_ln, r_st_col, sqltl_pkg::ERR_NONE);
                            do_begin = 1'b1;
                        end
                        w_cnt = w_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end
                end
                M_STRING, M_QIDENT: begin
                    if ((r_mode == M_STRING && c == "'") || (r_mode == M_QIDENT && c == "\"")) begin
                        t = (r_mode == M_STRING) ? sqltl_pkg::TOK_STRING : sqltl_pkg::TOK_IDENT;
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, t, 8'd0, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                        n_mode = M_IDLE;
                    end else if (c == "\\") begin
                        n_mode = (r_mode == M_STRING) ? M_STRING_ESC : M_QIDENT_ESC;
                    end else begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_STRING_ESC: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0,
                                         (c == "n") ? 8'd10 : (c == "t") ? 8'd9 :
                                         (c == "r") ? 8'd13 : c,
                                         r_st_ln, r_st_col, sqltl_pkg::ERR_NONE);
                    w_cnt = w_cnt + 2'd1;
                    n_mode = M_STRING;
                end
                M_QIDENT_ESC: begin
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_st_ln, r_st_col,
                                         sqltl_pkg::ERR_NONE);
                    w_cnt = w_cnt + 2'd1;
                    n_mode = M_QIDENT;
                end
                M_LINE_CMT: begin
                    if (c == 8'd10) n_mode = M_IDLE;
                end
                M_BLOCK_CMT: begin
                    if (c == "*") n_mode = M_BLOCK_STAR;
                end
                M_BLOCK_STAR: begin
                    if (c == "/") n_mode = M_IDLE;
                    else if (c != "*") n_mode = M_BLOCK_CMT;
                end
                M_PEND: begin
                    n_mode = M_IDLE;
                    if (r_pend == "-" && c == "-") begin
                        n_mode = M_LINE_CMT;
                    end else if (r_pend == "/" && c == "*") begin
                        n_mode = M_BLOCK_CMT;
                    end else if ((r_pend == "!" || r_pend == "|") &&
                                 !(r_pend == "!" && c == "=") && !(r_pend == "|" && c == "|")) begin
                        // lone '!' or '|'
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_st_ln,
                                             r_st_col, sqltl_pkg::ERR_BAD_CHAR);
                        w_cnt = w_cnt + 2'd1;
                        n_halt = 1'b1;
                    end else begin
                        // two-char forms consume c; one-char forms re-lex it
                        do_begin = 1'b1;
                        case (r_pend)
                            "-": t = sqltl_pkg::TOK_MINUS;
                            "/": t = sqltl_pkg::TOK_SLASH;
                            "<": begin
                                t = sqltl_pkg::TOK_LT;
                                if (c == "=") begin
                                    t = sqltl_pkg::TOK_LE; do_begin = 1'b0;
                                end else if (c == ">") begin
                                    t = sqltl_pkg::TOK_NE; do_begin = 1'b0;
                                end
                            end
                            ">": begin
                                t = sqltl_pkg::TOK_GT;
                                if (c == "=") begin
                                    t = sqltl_pkg::TOK_GE; do_begin = 1'b0;
                                end
                            end
                            "!": begin
                                t = sqltl_pkg::TOK_NE; do_begin = 1'b0;
                            end
                            default: begin
                                t = sqltl_pkg::TOK_CONCAT; do_begin = 1'b0;
                            end
                        endcase
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, t, 8'd0, r_st_ln, r_st_col,
                                             sqltl_pkg::ERR_NONE);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                default: begin
                    n_mode = M_IDLE;
                    do_begin = 1'b1;
                end
            endcase

            if (do_begin) begin
                n_st_ln  = r_cur_ln;
                n_st_col = r_cur_col;
                if (sqltl_pkg::is_space(c)) begin
                    n_mode = M_IDLE;
                end else if (c == "-" || c == "/" || c == "<" || c == ">" || c == "!" ||
                             c == "|") begin
                    n_pend = c;
                    n_mode = M_PEND;
                end else if (c == "'") begin
                    n_mode = M_STRING;
                end else if (c == "\"") begin
                    n_mode = M_QIDENT;
                end else if (sqltl_pkg::is_digit(c)) begin
                    n_mode   = M_NUMBER;
                    n_dot    = 1'b0;
                    n_lz     = (c == "0");
                    n_nmulti = 1'b0;
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_cur_ln, r_cur_col,
                                         sqltl_pkg::ERR_NONE);
                    w_cnt = w_cnt + 2'd1;
                end else if (sqltl_pkg::is_alpha(c) || c == "_") begin
                    n_mode    = M_IDENT;
                    n_long    = 1'b0;
                    n_kbuf[0] = sqltl_pkg::to_upper(c);
                    n_len     = LW'(1);
                    w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_VALUE, 7'd0, c, r_cur_ln, r_cur_col,
                                         sqltl_pkg::ERR_NONE);
                    w_cnt = w_cnt + 2'd1;
                end else begin
                    n_mode = M_IDLE;
                    case (c)
                        "(":     t = sqltl_pkg::TOK_LPAREN;
                        ")":     t = sqltl_pkg::TOK_RPAREN;
                        ",":     t = sqltl_pkg::TOK_COMMA;
                        ".":     t = sqltl_pkg::TOK_DOT;
                        ";":     t = sqltl_pkg::TOK_SEMI;
                        "*":     t = sqltl_pkg::TOK_STAR;
                        "=":     t = sqltl_pkg::TOK_EQ;
                        "+":     t = sqltl_pkg::TOK_PLUS;
                        "%":     t = sqltl_pkg::TOK_MOD;
                        default: t = sqltl_pkg::TOK_EOF;
                    endcase
                    if (t == sqltl_pkg::TOK_EOF) begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, r_cur_ln,
                                             r_cur_col, sqltl_pkg::ERR_BAD_CHAR);
                        n_halt = 1'b1;
                    end else begin
                        w_rec[w_cnt[0]] = mk(sqltl_pkg::REC_TOKEN, t, 8'd0, r_cur_ln,
                                             r_cur_col, sqltl_pkg::ERR_NONE);
                    end
                    w_cnt = w_cnt + 2'd1;
                end
            end

            if (c == 8'd10) begin
                n_cur_ln  = (r_cur_ln == '1) ? r_cur_ln : r_cur_ln + 1'b1;
                n_cur_col = PB'(1);
            end else begin
                n_cur_col = (r_cur_col == '1) ? r_cur_col : r_cur_col + 1'b1;
            end
        end

        if (i_end_of_text) begin
            n_mode    = M_IDLE;
            n_len     = '0;
            n_long    = 1'b0;
            n_pend    = 8'd0;
            n_dot     = 1'b0;
            n_lz      = 1'b0;
            n_nmulti  = 1'b0;
            n_cur_ln  = PB'(1);
            n_cur_col = PB'(1);
            n_st_ln   = PB'(1);
            n_st_col  = PB'(1);
            n_halt    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= M_IDLE;
            r_len     <= '0;
            r_long    <= 1'b0;
            r_pend    <= 8'd0;
            r_dot     <= 1'b0;
            r_lz      <= 1'b0;
            r_nmulti  <= 1'b0;
            r_cur_ln  <= PB'(1);
            r_cur_col <= PB'(1);
            r_st_ln   <= PB'(1);
            r_st_col  <= PB'(1);
            r_halt    <= 1'b0;
        end else if (w_in_acc) begin
            r_mode    <= n_mode;
            r_len     <= n_len;
            r_long    <= n_long;
            r_pend    <= n_pend;
            r_dot     <= n_dot;
            r_lz      <= n_lz;
            r_nmulti  <= n_nmulti;
            r_cur_ln  <= n_cur_ln;
            r_cur_col <= n_cur_col;
            r_st_ln   <= n_st_ln;
            r_st_col  <= n_st_col;
            r_halt    <= n_halt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) r_kbuf <= n_kbuf;
    end

    // output buffer: q0 is on the port, q1 waits behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qn <= 2'd0;
        end else if (w_in_acc && w_cnt != 2'd0) begin
            r_qn <= w_cnt;
        end else if (w_out_acc) begin
            r_qn <= r_qn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_cnt != 2'd0) begin
            r_q0 <= w_rec[0];
            r_q1 <= w_rec[1];
        end else if (w_out_acc) begin
            r_q0 <= r_q1;
        end
    end

    a_qn_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qn != 2'd3) else $error("output buffer count out of range");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halt && !i_end_of_text) |-> (w_cnt == 2'd0))
        else $error("records produced while halted");

    a_eot_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_end_of_text) |=> (r_mode == M_IDLE && !r_halt))
        else $error("lexer not re-armed after end of text");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_ln != '0) && (r_cur_col != '0) && (r_st_ln != '0) && (r_st_col != '0))
        else $error("position counter wrapped to zero");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qn == 2'd2) |-> !w_in_acc) else $error("input taken over full buffer");
endmodule

// File: verif/tb_sql_token_lexer_top.sv
`timescale 1ns / 100ps

module tb_sql_token_lexer_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_ITEMS  = 420;
    localparam int KMAX        = sqltl_pkg::KEYWORD_MAX_LEN;
    localparam logic [15:0] POS_SAT = 16'hFFFF;

    localparam logic [3:0] LX_IDLE    = 4'd0;
    localparam logic [3:0] LX_IDENT   = 4'd1;
    localparam logic [3:0] LX_NUM     = 4'd2;
    localparam logic [3:0] LX_STR     = 4'd3;
    localparam logic [3:0] LX_STR_ESC = 4'd4;
    localparam logic [3:0] LX_QID     = 4'd5;
    localparam logic [3:0] LX_QID_ESC = 4'd6;
    localparam logic [3:0] LX_LCMT    = 4'd7;
    localparam logic [3:0] LX_BCMT    = 4'd8;
    localparam logic [3:0] LX_BSTAR   = 4'd9;
    localparam logic [3:0] LX_PEND    = 4'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  ttype;
        logic [7:0]  vchar;
        logic [15:0] ln;
        logic [15:0] col;
        logic [2:0]  err;
        logic        last;
    } t_lex_rec;

    typedef struct {
        logic [7:0]  c;
        logic        eot;
        logic        typed;
        logic [1:0]  kind;
        logic [6:0]  tt;
        logic [2:0]  err;
        logic [15:0] ln;
        logic [15:0] col;
    } t_dir_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [7:0]               i_char_in = 8'd0;
    logic                     i_end_of_text = 1'b0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic [1:0]               o_record_kind;
    logic [6:0]               o_token_type;
    logic [7:0]               o_value_char;
    logic [15:0]              o_token_line;
    logic [15:0]              o_token_column;
    logic [2:0]               o_error_code;
    logic                     o_last;

    sql_token_lexer_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_char_in(i_char_in), .i_end_of_text(i_end_of_text),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_record_kind(o_record_kind), .o_token_type(o_token_type),
        .o_value_char(o_value_char), .o_token_line(o_token_line),
        .o_token_column(o_token_column), .o_error_code(o_error_code),
        .o_last(o_last)
    );

    always #10 i_clk = ~i_clk;

    string kw_list [69] = '{
        "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET",
        "DELETE", "CREATE", "TABLE", "DROP", "ALTER", "ADD", "MODIFY", "PRIMARY",
        "KEY", "NOT", "NULL", "UNIQUE", "FOREIGN", "REFERENCES", "DEFAULT",
        "CHECK", "CONSTRAINT", "AND", "OR", "IN", "BETWEEN", "LIKE", "IS",
        "ORDER", "BY", "GROUP", "HAVING", "LIMIT", "OFFSET", "DISTINCT", "INNER",
        "LEFT", "RIGHT", "FULL", "OUTER", "JOIN", "ON", "USING", "UNION",
        "INTERSECT", "EXCEPT", "CASE", "WHEN", "THEN", "ELSE", "END", "AS", "ASC",
        "DESC", "INT", "BIGINT", "FLOAT", "DOUBLE", "DECIMAL", "VARCHAR", "CHAR",
        "BOOLEAN", "DATE", "TIMESTAMP", "TEXT", "BLOB"
    };
    string op_list [19] = '{
        "=", "<>", "!=", "<", "<=", ">", ">=", "+", "-", "*", "/", "%", "||",
        "(", ")", ",", ".", ";", " "
    };

    // lexer mirror state
    logic [3:0]  lx_mode;
    logic [7:0]  kw_buf [KMAX];
    int          id_len;
    logic        id_long;
    logic [7:0]  pend_c;
    logic        got_dot;
    logic        lead0;
    logic [15:0] cur_ln, cur_col, st_ln, st_col;
    logic        halted;

    t_lex_rec    step_q [$];
    t_lex_rec    pending_recs [$];
    logic [7:0]  txt [$];

    int  n_errors, n_beats, n_recs, n_tok, n_err_recs;
    int  quiet;
    bit  idle_on = 1'b1;

    function automatic logic blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic letter_c(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction
    function automatic logic [7:0] upcase(logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic void lex_clear();
        lx_mode = LX_IDLE;
        foreach (kw_buf[i]) kw_buf[i] = 8'd0;
        id_len = 0; id_long = 0; pend_c = 8'd0; got_dot = 0; lead0 = 0;
        cur_ln = 16'd1; cur_col = 16'd1; st_ln = 16'd1; st_col = 16'd1;
        halted = 0;
    endfunction

    function automatic void put(logic [1:0] k, logic [6:0] t, logic [7:0] v,
                                logic [15:0] ln, logic [15:0] col, logic [2:0] e);
        t_lex_rec r;
        r = '{kind: k, ttype: t, vchar: v, ln: ln, col: col, err: e, last: 1'b0};
        if (step_q.size() < 3) step_q.insert(step_q.size(), r);
    endfunction

    function automatic void raise_err(logic [2:0] e, logic [15:0] ln, logic [15:0] col);
        put(sqltl_pkg::REC_ERROR, 7'd0, 8'd0, ln, col, e);
        halted = 1;
        lx_mode = LX_IDLE;
    endfunction

    function automatic void close_tok(logic [6:0] t);
        put(sqltl_pkg::REC_TOKEN, t, 8'd0, st_ln, st_col, sqltl_pkg::ERR_NONE);
        lx_mode = LX_IDLE;
    endfunction

    function automatic logic [6:0] word_type();
        logic same;
        if (id_long || id_len > 10) return sqltl_pkg::TOK_IDENT;
        for (int k = 0; k < 69; k++) begin
            same = (kw_list[k].len() == id_len);
            for (int i = 0; i < id_len && same; i++)
                if (kw_list[k][i] != kw_buf[i]) same = 0;
            if (same) return sqltl_pkg::TOK_KW0 + 7'(k);
        end
        return sqltl_pkg::TOK_IDENT;
    endfunction

    function automatic void close_num();
        if (!got_dot && lead0 && id_len > 1)
            raise_err(sqltl_pkg::ERR_LEAD_ZERO, st_ln, st_col);
        else
            close_tok(sqltl_pkg::TOK_NUMBER);
    endfunction

    function automatic void start_token(logic [7:0] c, logic [15:0] ln, logic [15:0] col);
        st_ln = ln;
        st_col = col;
        if (blank(c)) return;
        if (c == "-" || c == "/" || c == "<" || c == ">" || c == "!" || c == "|") begin
            pend_c = c;
            lx_mode = LX_PEND;
        end else if (c == "'") begin
            lx_mode = LX_STR;
        end else if (c == "\"") begin
            lx_mode = LX_QID;
        end else if (digit_c(c)) begin
            lx_mode = LX_NUM; got_dot = 0; lead0 = (c == "0"); id_len = 1;
            put(sqltl_pkg::REC_VALUE, 7'd0, c, ln, col, sqltl_pkg::ERR_NONE);
        end else if (letter_c(c) || c == "_") begin
            lx_mode = LX_IDENT; id_long = 0; kw_buf[0] = upcase(c); id_len = 1;
            put(sqltl_pkg::REC_VALUE, 7'd0, c, ln, col, sqltl_pkg::ERR_NONE);
        end else begin
            case (c)
                "(": close_tok(sqltl_pkg::TOK_LPAREN);
                ")": close_tok(sqltl_pkg::TOK_RPAREN);
                ",": close_tok(sqltl_pkg::TOK_COMMA);
                ".": close_tok(sqltl_pkg::TOK_DOT);
                ";": close_tok(sqltl_pkg::TOK_SEMI);
                "*": close_tok(sqltl_pkg::TOK_STAR);
                "=": close_tok(sqltl_pkg::TOK_EQ);
                "+": close_tok(sqltl_pkg::TOK_PLUS);
                "%": close_tok(sqltl_pkg::TOK_MOD);
                default: raise_err(sqltl_pkg::ERR_BAD_CHAR, ln, col);
            endcase
        end
    endfunction

    function automatic void feed(logic [7:0] c);
        logic [7:0] v;
        case (lx_mode)
            LX_IDENT: begin
                if (letter_c(c) || digit_c(c) || c == "_") begin
                    if (id_len >= KMAX) id_long = 1;
                    else begin kw_buf[id_len] = upcase(c); id_len++; end
                    put(sqltl_pkg::REC_VALUE, 7'd0, c, st_ln, st_col, sqltl_pkg::ERR_NONE);
                    return;
                end
                close_tok(word_type());
            end
            LX_NUM: begin
                if (digit_c(c) || (c == "." && !got_dot)) begin
                    if (c == ".") got_dot = 1;
                    if (id_len < 15) id_len++;
                    put(sqltl_pkg::REC_VALUE, 7'd0, c, st_ln, st_col, sqltl_pkg::ERR_NONE);
                    return;
                end
                close_num();
            end
            LX_STR: begin
                if (c == "'") close_tok(sqltl_pkg::TOK_STRING);
                else if (c == "\\") lx_mode = LX_STR_ESC;
                else put(sqltl_pkg::REC_VALUE, 7'd0, c, st_ln, st_col, sqltl_pkg::ERR_NONE);
                return;
            end
            LX_STR_ESC: begin
                v = (c == "n") ? 8'd10 : (c == "t") ? 8'd9 : (c == "r") ? 8'd13 : c;
                put(sqltl_pkg::REC_VALUE, 7'd0, v, st_ln, st_col, sqltl_pkg::ERR_NONE);
                lx_mode = LX_STR;
                return;
            end
            LX_QID: begin
                if (c == "\"") close_tok(sqltl_pkg::TOK_IDENT);
                else if (c == "\\") lx_mode = LX_QID_ESC;
                else put(sqltl_pkg::REC_VALUE, 7'd0, c, st_ln, st_col, sqltl_pkg::ERR_NONE);
                return;
            end
            LX_QID_ESC: begin
                put(sqltl_pkg::REC_VALUE, 7'd0, c, st_ln, st_col, sqltl_pkg::ERR_NONE);
                lx_mode = LX_QID;
                return;
            end
            LX_LCMT: begin
                if (c == 8'd10) lx_mode = LX_IDLE;
                return;
            end
            LX_BCMT: begin
                if (c == "*") lx_mode = LX_BSTAR;
                return;
            end
            LX_BSTAR: begin
                if (c == "/") lx_mode = LX_IDLE;
                else if (c != "*") lx_mode = LX_BCMT;
                return;
            end
            LX_PEND: begin
                case (pend_c)
                    "-": begin
                        if (c == "-") begin lx_mode = LX_LCMT; return; end
                        close_tok(sqltl_pkg::TOK_MINUS);
                    end
                    "/": begin
                        if (c == "*") begin lx_mode = LX_BCMT; return; end
                        close_tok(sqltl_pkg::TOK_SLASH);
                    end
                    "<": begin
                        if (c == "=") begin close_tok(sqltl_pkg::TOK_LE); return; end
                        if (c == ">") begin close_tok(sqltl_pkg::TOK_NE); return; end
                        close_tok(sqltl_pkg::TOK_LT);
                    end
                    ">": begin
                        if (c == "=") begin close_tok(sqltl_pkg::TOK_GE); return; end
                        close_tok(sqltl_pkg::TOK_GT);
                    end
                    "!": begin
                        if (c == "=") close_tok(sqltl_pkg::TOK_NE);
                        else raise_err(sqltl_pkg::ERR_BAD_CHAR, st_ln, st_col);
                        return;
                    end
                    default: begin
                        if (c == "|") close_tok(sqltl_pkg::TOK_CONCAT);
                        else raise_err(sqltl_pkg::ERR_BAD_CHAR, st_ln, st_col);
                        return;
                    end
                endcase
            end
            default: lx_mode = LX_IDLE;
        endcase
        // the byte that ended the previous token starts the next one
        if (!halted) start_token(c, cur_ln, cur_col);
    endfunction

    function automatic void flush_text();
        case (lx_mode)
            LX_IDENT:              close_tok(word_type());
            LX_NUM:                close_num();
            LX_STR, LX_STR_ESC:    raise_err(sqltl_pkg::ERR_STRING, st_ln, st_col);
            LX_QID, LX_QID_ESC:    raise_err(sqltl_pkg::ERR_QIDENT, st_ln, st_col);
            LX_BCMT, LX_BSTAR:     raise_err(sqltl_pkg::ERR_BLOCK_CMT, st_ln, st_col);
            LX_PEND: begin
                if (pend_c == "-") close_tok(sqltl_pkg::TOK_MINUS);
                else if (pend_c == "/") close_tok(sqltl_pkg::TOK_SLASH);
                else if (pend_c == "<") close_tok(sqltl_pkg::TOK_LT);
                else if (pend_c == ">") close_tok(sqltl_pkg::TOK_GT);
                else raise_err(sqltl_pkg::ERR_BAD_CHAR, st_ln, st_col);
            end
            default: ;
        endcase
        if (!halted)
            put(sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_EOF, 8'd0, cur_ln, cur_col,
                sqltl_pkg::ERR_NONE);
        lx_mode = LX_IDLE;
    endfunction

    function automatic void lex_byte(logic [7:0] c, logic eot);
        step_q.delete();
        if (eot) begin
            if (!halted) flush_text();
            lex_clear();
        end else if (halted) begin
        end else if (c == 8'd0) begin
            // embedded NUL ends the text
            flush_text();
            halted = 1;
        end else begin
            feed(c);
            if (c == 8'd10) begin
                if (cur_ln < POS_SAT) cur_ln++;
                cur_col = 16'd1;
            end else if (cur_col < POS_SAT) begin
                cur_col++;
            end
        end
        if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    endfunction

    function automatic void add_ch(logic [7:0] ch);
        txt.insert(txt.size(), ch);
    endfunction

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task automatic send_beat(input logic [7:0] c, input logic eot,
                             input logic typed = 1'b0, input t_lex_rec want = '0);
        int  gap;
        bit  acc;
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= c;
        i_end_of_text <= eot;
        do begin
            @(negedge i_clk);
            acc = !o_stall;
            @(posedge i_clk);
        end while (!acc);
        n_beats++;
        lex_byte(c, eot);
        if (typed) pending_recs.insert(pending_recs.size(), want);
        else foreach (step_q[i]) pending_recs.insert(pending_recs.size(), step_q[i]);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) add_ch(s[i]);
    endtask

    task automatic add_word(input int n);
        logic [7:0] ch;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: ch = "a" + 8'($urandom_range(0, 25));
                1: ch = "A" + 8'($urandom_range(0, 25));
                2: ch = (i == 0) ? "_" : "0" + 8'($urandom_range(0, 9));
                default: ch = "_";
            endcase
            add_ch(ch);
        end
    endtask

    task automatic add_piece();
        string s;
        int    n;
        logic [7:0] ch;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                s = kw_list[$urandom_range(0, 68)];
                for (int i = 0; i < s.len(); i++)
                    add_ch($urandom_range(0, 1) ? 8'(s[i] + 8'd32) : 8'(s[i]));
            end
            3, 4: add_word($urandom_range(0, 3) == 0 ? $urandom_range(9, 14)
                                                      : $urandom_range(1, 6));
            5, 6: begin
                n = $urandom_range(1, 6);
                add_ch($urandom_range(0, 3) == 0 ? "0" : "1" + 8'($urandom_range(0, 8)));
                for (int i = 1; i < n; i++) add_ch("0" + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 2) == 0) add_ch(".");
                if ($urandom_range(0, 1)) add_ch("0" + 8'($urandom_range(0, 9)));
            end
            7, 8: begin
                ch = $urandom_range(0, 1) ? "'" : "\"";
                add_ch(ch);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    case ($urandom_range(0, 4))
                        0: begin add_ch("\\"); add_str($urandom_range(0, 1) ? "n" : "t"); end
                        1: begin add_ch("\\"); add_ch($urandom_range(0, 1) ? "r" : ch); end
                        2: add_ch(8'($urandom_range(128, 255)));
                        default: add_ch(8'($urandom_range(32, 126)));
                    endcase
                    if (txt[$] == ch && txt[txt.size()-2] != "\\") txt[$] = "x";
                end
                add_ch(ch);
            end
            9, 10, 11: add_str(op_list[$urandom_range(0, 18)]);
            12: begin
                case ($urandom_range(0, 3))
                    0: add_ch(8'd9);
                    1: add_ch(8'd10);
                    2: add_ch(8'd11 + 8'($urandom_range(0, 2)));
                    default: add_ch(" ");
                endcase
            end
            13: begin
                add_str("-- ");
                add_ch(8'($urandom_range(1, 255)));
                add_ch(8'd10);
            end
            14: begin
                add_str("/* *");
                add_ch(8'($urandom_range(1, 255)));
                add_str("**/");
            end
            default: add_ch(8'($urandom_range(1, 255)));
        endcase
        if ($urandom_range(0, 1)) add_ch($urandom_range(0, 3) ? " " : 8'd10);
    endtask

    task automatic run_text();
        int n;
        txt.delete();
        n = $urandom_range(3, 14);
        for (int i = 0; i < n; i++) add_piece();
        // sometimes leave a construct open or drop in a NUL
        case ($urandom_range(0, 9))
            0: add_str("'ab");
            1: add_str("\"q\\");
            2: add_str("/* x");
            3: add_str($urandom_range(0, 1) ? "!" : "|");
            4: begin add_ch(8'd0); add_str("k'"); end
            5: add_str($urandom_range(0, 1) ? "<" : "-");
            default: ;
        endcase
        foreach (txt[i]) send_beat(txt[i], 1'b0);
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    t_dir_row dir_rows [24] = '{
        '{8'd0,  1, 1, sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_EOF, sqltl_pkg::ERR_NONE,
          16'd1, 16'd1},
        '{"(",   0, 1, sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_LPAREN, sqltl_pkg::ERR_NONE,
          16'd1, 16'd1},
        '{8'h80, 0, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_BAD_CHAR, 16'd1, 16'd2},
        '{"x",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'hFF, 1, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"0",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"7",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'd0,  1, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_LEAD_ZERO, 16'd1, 16'd1},
        '{"'",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'd0,  1, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_STRING, 16'd1, 16'd1},
        '{"\"",  0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'd0,  1, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_QIDENT, 16'd1, 16'd1},
        '{"/",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"*",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'd0,  1, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_BLOCK_CMT, 16'd1, 16'd1},
        '{"!",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"=",   0, 1, sqltl_pkg::REC_TOKEN, sqltl_pkg::TOK_NE, sqltl_pkg::ERR_NONE,
          16'd1, 16'd1},
        '{"|",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"q",   0, 1, sqltl_pkg::REC_ERROR, 7'd0, sqltl_pkg::ERR_BAD_CHAR, 16'd1, 16'd3},
        '{8'h00, 1, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"z",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'h00, 0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{"k",   0, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0},
        '{8'h5A, 1, 0, 2'd0, 7'd0, sqltl_pkg::ERR_NONE, 16'd0, 16'd0}
    };

    // result side: random stall, check at the negedge before the accepting edge
    initial begin : result_sink
        int       gap;
        bit       got;
        t_lex_rec want;
        @(posedge i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do begin
                @(negedge i_clk);
                got = o_valid;
                if (got) begin
                    n_recs++;
                    if (o_record_kind == sqltl_pkg::REC_TOKEN) n_tok++;
                    if (o_record_kind == sqltl_pkg::REC_ERROR) n_err_recs++;
                    if (pending_recs.size() == 0) begin
                        report_mismatch("record with nothing expected");
                    end else begin
                        want = pending_recs.pop_front();
                        if (o_record_kind !== want.kind)
                            report_mismatch($sformatf("kind %0d want %0d", o_record_kind,
                                                      want.kind));
                        if (o_token_type !== want.ttype)
                            report_mismatch($sformatf("type %0d want %0d", o_token_type,
                                                      want.ttype));
                        if (o_value_char !== want.vchar)
                            report_mismatch($sformatf("char %0h want %0h", o_value_char,
                                                      want.vchar));
                        if (o_token_line !== want.ln)
                            report_mismatch($sformatf("line %0d want %0d", o_token_line,
                                                      want.ln));
                        if (o_token_column !== want.col)
                            report_mismatch($sformatf("col %0d want %0d", o_token_column,
                                                      want.col));
                        if (o_error_code !== want.err)
                            report_mismatch($sformatf("err %0d want %0d", o_error_code,
                                                      want.err));
                        if (o_last !== want.last)
                            report_mismatch($sformatf("last %0b want %0b", o_last, want.last));
                    end
                end
                @(posedge i_clk);
            end while (!got);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet);
            $display("** sql_token_lexer_top: FAILED **");
            $finish;
        end
    end

    initial begin : stim
        t_lex_rec r;
        bit       paused;
        paused = 1'b0;
        lex_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            r = '{kind: dir_rows[i].kind, ttype: dir_rows[i].tt, vchar: 8'd0,
                  ln: dir_rows[i].ln, col: dir_rows[i].col, err: dir_rows[i].err,
                  last: 1'b1};
            send_beat(dir_rows[i].c, dir_rows[i].eot, dir_rows[i].typed, r);
        end

        for (int base = n_beats; n_beats - base < RAND_ITEMS; ) begin
            if ($urandom_range(0, 4) == 0) idle_on = ~idle_on;
            run_text();
            // drain everything once mid-run
            if (!paused && n_beats - base > RAND_ITEMS / 2) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                wait (pending_recs.size() == 0);
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;
        wait (pending_recs.size() == 0);
        repeat (20) @(posedge i_clk);

        $display("drove %0d beats of directed rows and random SQL text; checked %0d records",
                 n_beats, n_recs);
        $display("(%0d token ends, %0d error reports)", n_tok, n_err_recs);
        if (n_errors == 0 && pending_recs.size() == 0) begin
            $display("** sql_token_lexer_top: PASSED **");
        end else begin
            $display("** sql_token_lexer_top: FAILED **");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/sqltl_pkg.sv
hdl/sqltl_kw_match.sv
hdl/sql_token_lexer_top.sv
verif/tb_sql_token_lexer_top.sv
